[rtl/mtcm_pkg.sv]
// ----------------------------------------------------------------------------
// mtcm_pkg: shared types and constants of the mirrored tile coordinate map
// Register indexes, fixed-point widths and the divider stage record.
// ----------------------------------------------------------------------------
`default_nettype none

package mtcm_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_TILES_ACROSS  = 3'd2,
        REG_TILES_DOWN    = 3'd3,
        REG_SHIFT_X       = 3'd4,
        REG_SHIFT_Y       = 3'd5,
        REG_MIRROR_ENABLE = 3'd6
    } cfg_reg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Field widths.
    localparam int COORD_W = 12;
    localparam int SIZE_W  = 13;
    localparam int TILES_W = 16;
    localparam int SHIFT_W = 16;

    // The normalized coordinate carries 16 fraction bits; the product with
    // the Q6.10 tile count carries 26.
    localparam int NORM_FRAC = 16;
    localparam int FRAC_BITS = 26;
    localparam int QUOT_W    = COORD_W + NORM_FRAC;
    localparam int CELL_W    = FRAC_BITS + 1;

    // Pipelined restoring divider: quotient bits resolved per stage.
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = QUOT_W / DIV_STEPS;

    // One divider lane: partial remainder and the shifting dividend/quotient.
    typedef struct packed {
        logic [SIZE_W-1:0] rem;
        logic [QUOT_W-1:0] qd;
    } div_t;

endpackage

`default_nettype wire

[rtl/mirror_tile_coordinate_map_top.sv]
// ----------------------------------------------------------------------------
// mirror_tile_coordinate_map_top: destination to source pixel coordinate map
// Normalizes each coordinate by the image size, applies offset and tile
// count, reflects odd cells in mirror mode, and rescales to the image.
// ----------------------------------------------------------------------------
//
//   Channel  | Signals                                 | Direction
//   ---------+-----------------------------------------+----------
//   input    | in_valid, in_ready, dest_x, dest_y      | in
//   output   | out_valid, out_ready, src_x, src_y      | out
//   config   | cfg_we, cfg_index, cfg_wdata            | in
//
// One item enters per cycle while the pipeline is not stalled.
// The pipeline is the seven-stage divider (4 quotient bits per stage)
// followed by offset, tile multiply, reflect, rescale multiply and clamp.
// When the output register holds an untaken item the whole pipeline stalls
// in place, and in_ready drops in the same cycle. Reset clears the valid
// bits and loads the configuration reset values; no clearing pass is needed.
//
`default_nettype none

module mirror_tile_coordinate_map_top #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [mtcm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [mtcm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [mtcm_pkg::COORD_W-1:0]       dest_x,
    input  wire logic [mtcm_pkg::COORD_W-1:0]       dest_y,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [mtcm_pkg::COORD_W-1:0]            src_x,
    output logic [mtcm_pkg::COORD_W-1:0]            src_y
);
    import mtcm_pkg::*;

    // Upper bound on any result, from the dimension limit and the port width.
    localparam int LIM_CAP = (MAX_DIM - 1 < (1 << COORD_W) - 1) ?
                             MAX_DIM - 1 : (1 << COORD_W) - 1;
    localparam logic [SIZE_W-1:0] LIM_CAP_V = SIZE_W'(LIM_CAP);

    localparam int ST_SUB   = DIV_STAGES;
    localparam int ST_MUL   = DIV_STAGES + 1;
    localparam int ST_MIR   = DIV_STAGES + 2;
    localparam int ST_SCL   = DIV_STAGES + 3;
    localparam int ST_OUT   = DIV_STAGES + 4;
    localparam int N_STAGES = DIV_STAGES + 5;

    localparam int PROD_W  = CELL_W + SIZE_W;
    localparam int RES_W   = PROD_W + 1 - FRAC_BITS;
    localparam logic [CELL_W-1:0] ONE_Q = CELL_W'(1) << FRAC_BITS;
    localparam logic [PROD_W:0]   HALF_Q = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    // Configuration registers.
    logic [SIZE_W-1:0]  image_width_reg, image_height_reg;
    logic [TILES_W-1:0] tiles_across_reg, tiles_down_reg;
    logic [SHIFT_W-1:0] shift_x_reg, shift_y_reg;
    logic               mirror_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= SIZE_W'(1024);
            image_height_reg  <= SIZE_W'(1024);
            tiles_across_reg  <= TILES_W'(3072);
            tiles_down_reg    <= TILES_W'(3072);
            shift_x_reg       <= '0;
            shift_y_reg       <= '0;
            mirror_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_wdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_TILES_ACROSS:  tiles_across_reg  <= cfg_wdata[TILES_W-1:0];
                REG_TILES_DOWN:    tiles_down_reg    <= cfg_wdata[TILES_W-1:0];
                REG_SHIFT_X:       shift_x_reg       <= cfg_wdata[SHIFT_W-1:0];
                REG_SHIFT_Y:       shift_y_reg       <= cfg_wdata[SHIFT_W-1:0];
                REG_MIRROR_ENABLE: mirror_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Per-axis view of the configuration. A zero size counts as one.
    logic [SIZE_W-1:0]  size_eff [2];
    logic [SIZE_W-1:0]  size_m1  [2];
    logic [SIZE_W-1:0]  lim      [2];
    logic [TILES_W-1:0] tiles    [2];
    logic [SHIFT_W-1:0] shift    [2];
    logic [COORD_W-1:0] dest     [2];

    always_comb
    begin
        size_eff[0] = (image_width_reg == '0)  ? SIZE_W'(1) : image_width_reg;
        size_eff[1] = (image_height_reg == '0) ? SIZE_W'(1) : image_height_reg;
        tiles[0]    = tiles_across_reg;
        tiles[1]    = tiles_down_reg;
        shift[0]    = shift_x_reg;
        shift[1]    = shift_y_reg;
        dest[0]     = dest_x;
        dest[1]     = dest_y;
        for (int a = 0; a < 2; a++)
        begin
            size_m1[a] = size_eff[a] - SIZE_W'(1);
            lim[a]     = (size_m1[a] > LIM_CAP_V) ? LIM_CAP_V : size_m1[a];
        end
    end

    // Global advance: the pipeline moves whenever the output slot is free.
    logic adv;
    logic vld_reg [N_STAGES];

    assign adv      = !vld_reg[ST_OUT] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < N_STAGES; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Several restoring division steps: shift in one dividend bit, subtract
    // the divisor when it fits, and shift in the quotient bit.
    function automatic div_t div_steps(div_t x, logic [SIZE_W-1:0] dvs);
        logic [SIZE_W:0] trial;
        div_t            y;
        y = x;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial = {y.rem, y.qd[QUOT_W-1]};
            if (trial >= {1'b0, dvs})
            begin
                trial = trial - {1'b0, dvs};
                y.qd  = {y.qd[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                y.qd  = {y.qd[QUOT_W-2:0], 1'b0};
            end
            y.rem = trial[SIZE_W-1:0];
        end
        return y;
    endfunction

    // Payload registers of the arithmetic stages, one lane per axis.
    logic [CELL_W-1:0]    v_reg    [2];
    logic [CELL_W-1:0]    n_reg    [2];
    logic [CELL_W-1:0]    frac_reg [2];
    logic [PROD_W-1:0]    prod_reg [2];
    logic [COORD_W-1:0]   res_reg  [2];

    for (genvar a = 0; a < 2; a++)
    begin : g_axis
        div_t                div_reg [DIV_STAGES];
        div_t                div_in;
        logic [CELL_W-1:0]   shift_q;
        logic [CELL_W+TILES_W-1:0] n_full;
        logic [CELL_W-1:0]   frac_n;
        logic [PROD_W:0]     rounded;
        logic [RES_W-1:0]    r_val;

        assign div_in.rem = '0;
        assign div_in.qd  = {dest[a], NORM_FRAC'(0)};

        // Divider stages: the first takes the new item directly.
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[0] <= div_steps(div_in, size_eff[a]);
                for (int s = 1; s < DIV_STAGES; s++)
                begin
                    div_reg[s] <= div_steps(div_reg[s-1], size_eff[a]);
                end
            end
        end

        // Offset in Q.16, kept modulo the cell parity bit.
        assign shift_q = {{(CELL_W - SHIFT_W - 4){shift[a][SHIFT_W-1]}},
                          shift[a], 4'b0000};

        // Tile multiply; only the fraction and the parity bit matter.
        assign n_full = v_reg[a] * tiles[a];

        // Reflect the fraction of odd cells in mirror mode.
        always_comb
        begin
            if (mirror_enable_reg && n_reg[a][FRAC_BITS])
            begin
                frac_n = ONE_Q - {1'b0, n_reg[a][FRAC_BITS-1:0]};
            end
            else
            begin
                frac_n = {1'b0, n_reg[a][FRAC_BITS-1:0]};
            end
        end

        // Round half up, then clamp to the image.
        assign rounded = {1'b0, prod_reg[a]} + HALF_Q;
        assign r_val   = rounded[PROD_W:FRAC_BITS];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                v_reg[a]    <= div_reg[DIV_STAGES-1].qd[CELL_W-1:0] - shift_q;
                n_reg[a]    <= n_full[CELL_W-1:0];
                frac_reg[a] <= frac_n;
                prod_reg[a] <= frac_reg[a] * size_m1[a];
                if (r_val > RES_W'(lim[a]))
                begin
                    res_reg[a] <= lim[a][COORD_W-1:0];
                end
                else
                begin
                    res_reg[a] <= r_val[COORD_W-1:0];
                end
            end
        end
    end

    assign out_valid = vld_reg[ST_OUT];
    assign src_x     = res_reg[0];
    assign src_y     = res_reg[1];

    // An accepted item occupies the first stage on the next edge.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted item did not enter the pipeline");

    // A stalled pipeline keeps the items of the offset, multiply, reflect and rescale stages where they are.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> vld_reg[ST_SUB] == $past(vld_reg[ST_SUB]) &&
                 vld_reg[ST_MUL] == $past(vld_reg[ST_MUL]) &&
                 vld_reg[ST_MIR] == $past(vld_reg[ST_MIR]) &&
                 vld_reg[ST_SCL] == $past(vld_reg[ST_SCL]))
        else $error("stall moved an item");

    // Results never leave the clamp range.
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, src_x} <= lim[0] && {1'b0, src_y} <= lim[1])
        else $error("result beyond clamp limit");

endmodule

`default_nettype wire
